// ===== rtl/mandelbrot_escape_time_pixel_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Mandelbrot escape-time pixel block
// Concurrent checks that are compiled for simulation and left empty for
// synthesis.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// The antecedent implies the consequent in the same cycle.
`define MBE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mbe: implication check failed");

// The expression never holds outside reset.
`define MBE_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("mbe: forbidden condition seen");

`else

`define MBE_ASSERT_IMP(lbl, ante, cons)
`define MBE_ASSERT_NEVER(lbl, expr)

`endif

`endif

// ===== rtl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Types, constants and helper functions shared by the escape-time modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  // Fixed-point format: signed words with four integer bits.
  localparam int FRAC_BITS    = 28;
  localparam int COORD_BITS   = 11;
  localparam int WORD_W       = FRAC_BITS + 4;
  localparam int PROD_W       = 2 * WORD_W;
  localparam int SUM_W        = PROD_W - FRAC_BITS + 3;
  localparam int STEP_W       = 29;
  localparam int COORD_PROD_W = STEP_W + COORD_BITS;
  localparam int SAT_W        = (COORD_PROD_W + 1 > SUM_W) ? COORD_PROD_W + 1 : SUM_W;
  localparam int CNT_W        = 8;

  // Reorder buffer sizing; it must cover every item inside the loop.
  localparam int ROB_DEPTH = 4;
  localparam int TAG_W     = $clog2(ROB_DEPTH);
  localparam int OCC_W     = $clog2(ROB_DEPTH + 1);

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y   = 2'd2;
  localparam logic [CNT_W-1:0]  MAX_ITER_RST = 8'd28;
  localparam logic [STEP_W-1:0] STEP_X_RST   = 29'd838861;
  localparam logic [STEP_W-1:0] STEP_Y_RST   = 29'd1491308;

  // Escape threshold 4.0 expressed on the unshifted squares.
  localparam logic [PROD_W:0] ESC_LIMIT = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 2);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [TAG_W-1:0]         tag_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // One item in the orbit loop, holding z after cnt iterations.
  typedef struct packed {
    logic  valid;
    word_t re;
    word_t im;
    word_t c_re;
    word_t c_im;
    cnt_t  cnt;
    tag_t  tag;
  } orbit_t;

  // Item after the squaring stage.
  typedef struct packed {
    logic              valid;
    logic [PROD_W-1:0] rr;
    logic [PROD_W-1:0] ii;
    logic [PROD_W-1:0] ri;
    logic              neg;
    word_t             c_re;
    word_t             c_im;
    cnt_t              cnt;
    tag_t              tag;
  } prod_t;

  // A finished item leaving the loop.
  typedef struct packed {
    logic valid;
    tag_t tag;
    cnt_t cnt;
  } retire_t;

  // Reorder buffer status seen by the top level.
  typedef struct packed {
    logic room;
    logic empty;
    tag_t tag;
  } rob_status_t;

  // Clamp a wide signed value to the word range.
  function automatic word_t sat_word(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-WORD_W:0] hi;
    hi = v[SAT_W-1:WORD_W-1];
    if ((&hi) || !(|hi)) begin
      return v[WORD_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mbe_coord.sv =====
// ----------------------------------------------------------------------------
// mbe_coord
// Maps a pixel index to one component of c: step * pixel - 2, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_coord (
  input  wire logic [mbe_pkg::STEP_W-1:0]     step_i,
  input  wire logic [mbe_pkg::COORD_BITS-1:0] pixel_i,
  output mbe_pkg::word_t                      coord_o
);

  localparam logic signed [mbe_pkg::SAT_W-1:0] OFFSET =
    mbe_pkg::SAT_W'(2) << mbe_pkg::FRAC_BITS;

  logic [mbe_pkg::COORD_PROD_W-1:0] prod;
  logic signed [mbe_pkg::SAT_W-1:0] diff;

  // The product is never negative, so only the upper bound can clip.
  always_comb begin
    prod    = mbe_pkg::COORD_PROD_W'(step_i) * mbe_pkg::COORD_PROD_W'(pixel_i);
    diff    = $signed({{(mbe_pkg::SAT_W - mbe_pkg::COORD_PROD_W){1'b0}}, prod}) - OFFSET;
    coord_o = mbe_pkg::sat_word(diff);
  end

endmodule

`default_nettype wire

// ===== rtl/mbe_iter.sv =====
// ----------------------------------------------------------------------------
// mbe_iter
// Three-stage orbit loop: magnitudes and squares, then escape test and
// update. Up to three items circulate, one per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_iter (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            ins_valid_i,
  input  wire mbe_pkg::orbit_t ins_item_i,
  input  wire mbe_pkg::cnt_t   limit_i,
  output logic                 slot_free_o,
  output logic                 busy_o,
  output mbe_pkg::retire_t     retire_o
);

  localparam int W  = mbe_pkg::WORD_W;
  localparam int F  = mbe_pkg::FRAC_BITS;
  localparam int PW = mbe_pkg::PROD_W;
  localparam int SW = mbe_pkg::SUM_W;

  mbe_pkg::orbit_t p_q, p_d;
  mbe_pkg::prod_t  m_q, m_d;
  mbe_pkg::orbit_t u_q, u_d;

  logic [W-1:0]   ar, ai;
  logic [PW:0]    esc_sum;
  logic           esc, done;
  logic signed [SW-1:0] rr_s, ii_s, ri_mag, ri_s, cre_s, cim_s, nre, nim;

  // A new item may enter only where no item comes round from the update stage.
  assign slot_free_o = !u_q.valid;
  assign busy_o      = p_q.valid || m_q.valid || u_q.valid;

  always_comb begin
    if (u_q.valid) begin
      p_d = u_q;
    end else if (ins_valid_i) begin
      p_d = ins_item_i;
    end else begin
      p_d = '0;
    end
  end

  // Squaring stage: magnitudes of z and the three partial products.
  always_comb begin
    ar        = p_q.re[W-1] ? (~p_q.re + 1'b1) : p_q.re;
    ai        = p_q.im[W-1] ? (~p_q.im + 1'b1) : p_q.im;
    m_d.valid = p_q.valid;
    m_d.rr    = PW'(ar) * PW'(ar);
    m_d.ii    = PW'(ai) * PW'(ai);
    m_d.ri    = PW'(ar) * PW'(ai);
    m_d.neg   = p_q.re[W-1] ^ p_q.im[W-1];
    m_d.c_re  = p_q.c_re;
    m_d.c_im  = p_q.c_im;
    m_d.cnt   = p_q.cnt;
    m_d.tag   = p_q.tag;
  end

  // Update stage: the squares of z also give the escape test of z itself,
  // so an item retires here before a further step is taken.
  always_comb begin
    esc_sum = {1'b0, m_q.rr} + {1'b0, m_q.ii};
    esc     = esc_sum >= mbe_pkg::ESC_LIMIT;
    done    = esc || (m_q.cnt >= limit_i);

    rr_s   = $signed(SW'(m_q.rr[PW-1:F]));
    ii_s   = $signed(SW'(m_q.ii[PW-1:F]));
    ri_mag = $signed(SW'(m_q.ri[PW-1:F-1]));
    // Floor toward minus infinity rounds a negative cross term away from zero.
    if (m_q.neg) begin
      ri_s = -(ri_mag + $signed(SW'(|m_q.ri[F-2:0])));
    end else begin
      ri_s = ri_mag;
    end
    cre_s = $signed({{(SW - W){m_q.c_re[W-1]}}, m_q.c_re});
    cim_s = $signed({{(SW - W){m_q.c_im[W-1]}}, m_q.c_im});
    nre   = rr_s - ii_s + cre_s;
    nim   = ri_s + cim_s;

    retire_o.valid = m_q.valid && done;
    retire_o.tag   = m_q.tag;
    retire_o.cnt   = m_q.cnt;

    u_d.valid = m_q.valid && !done;
    u_d.re    = mbe_pkg::sat_word(mbe_pkg::SAT_W'(nre));
    u_d.im    = mbe_pkg::sat_word(mbe_pkg::SAT_W'(nim));
    u_d.c_re  = m_q.c_re;
    u_d.c_im  = m_q.c_im;
    u_d.cnt   = m_q.cnt + 1'b1;
    u_d.tag   = m_q.tag;
  end

  // Loop registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
      m_q <= '0;
      u_q <= '0;
    end else begin
      p_q <= p_d;
      m_q <= m_d;
      u_q <= u_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mbe_rob.sv =====
// ----------------------------------------------------------------------------
// mbe_rob
// Reorder buffer and output register. Items leave the loop in any order and
// are handed on in the order in which they were accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_rob (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  ins_i,
  input  wire mbe_pkg::retire_t      retire_i,
  input  wire logic                  out_stall_i,
  output mbe_pkg::rob_status_t       status_o,
  output logic                       out_valid_o,
  output logic [mbe_pkg::CNT_W-1:0]  escape_count_o,
  output logic [mbe_pkg::CNT_W-1:0]  red_level_o
);

  mbe_pkg::cnt_t                     cnt_q [mbe_pkg::ROB_DEPTH];
  logic [mbe_pkg::ROB_DEPTH-1:0]     valid_q, valid_d;
  mbe_pkg::tag_t                     head_q, head_d;
  mbe_pkg::tag_t                     tail_q, tail_d;
  logic [mbe_pkg::OCC_W-1:0]         occ_q, occ_d;
  logic                              out_v_q, out_v_d;
  mbe_pkg::cnt_t                     count_q, red_q;
  mbe_pkg::cnt_t                     head_cnt;
  logic                              pop;

  assign status_o.room  = occ_q < mbe_pkg::OCC_W'(mbe_pkg::ROB_DEPTH);
  assign status_o.empty = occ_q == '0;
  assign status_o.tag   = tail_q;

  assign head_cnt = cnt_q[head_q];
  assign pop      = valid_q[head_q] && (!out_v_q || !out_stall_i);

  // Bookkeeping of entries, pointers and occupancy.
  always_comb begin
    valid_d = valid_q;
    if (pop) begin
      valid_d[head_q] = 1'b0;
    end
    if (retire_i.valid) begin
      valid_d[retire_i.tag] = 1'b1;
    end
    head_d  = head_q + mbe_pkg::TAG_W'(pop);
    tail_d  = tail_q + mbe_pkg::TAG_W'(ins_i);
    occ_d   = occ_q + mbe_pkg::OCC_W'(ins_i) - mbe_pkg::OCC_W'(pop);
    out_v_d = pop || (out_v_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      out_v_q <= out_v_d;
    end
  end

  // Counts are stored by tag as items finish.
  always_ff @(posedge clk_i) begin
    if (retire_i.valid) begin
      cnt_q[retire_i.tag] <= retire_i.cnt;
    end
  end

  // Output register; the red byte is count * 10 kept to eight bits.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      count_q <= head_cnt;
      red_q   <= (head_cnt << 3) + (head_cnt << 1);
    end
  end

  assign out_valid_o    = out_v_q;
  assign escape_count_o = count_q;
  assign red_level_o    = red_q;

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_time_pixel_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top
// Escape-time evaluator for one pixel of the Mandelbrot set in Q4.28.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o  pixel_x_i, pixel_y_i
//   out      output     out_valid_o / out_stall_i escape_count_o, red_level_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each iteration passes once round the orbit loop, through every stage.
// Up to three pixels share the loop, one per stage, so a full loop
// finishes about one iteration per cycle.
// Results are reordered and leave in acceptance order.
// Reset empties the loop and the reorder buffer and loads the default registers.
// A stalled output holds its result; input is stalled while the loop or the
// reorder buffer has no room.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mandelbrot_escape_time_pixel_top_defines.svh"

module mandelbrot_escape_time_pixel_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [10:0]                   pixel_x_i,
  input  wire logic [10:0]                   pixel_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         escape_count_o,
  output logic [7:0]                         red_level_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mbe_pkg::STEP_W-1:0]    cfg_data_i
);

  mbe_pkg::cnt_t                 max_iter_q;
  logic [mbe_pkg::STEP_W-1:0]    step_x_q;
  logic [mbe_pkg::STEP_W-1:0]    step_y_q;
  mbe_pkg::cnt_t                 limit;
  mbe_pkg::word_t                c_re, c_im;
  mbe_pkg::orbit_t               ins_item;
  mbe_pkg::retire_t              retire;
  mbe_pkg::rob_status_t          rob_st;
  logic                          slot_free, loop_busy, accept;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= mbe_pkg::MAX_ITER_RST;
      step_x_q   <= mbe_pkg::STEP_X_RST;
      step_y_q   <= mbe_pkg::STEP_Y_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mbe_pkg::CFG_MAX_ITER: max_iter_q <= cfg_data_i[mbe_pkg::CNT_W-1:0];
        mbe_pkg::CFG_STEP_X:   step_x_q   <= cfg_data_i;
        mbe_pkg::CFG_STEP_Y:   step_y_q   <= cfg_data_i;
        default:               ;
      endcase
    end
  end

  // Step limit: one less than the cap, never below one.
  assign limit = (max_iter_q > 8'd2) ? (max_iter_q - 1'b1) : 8'd1;

  // Input transfer needs a free loop slot and a reorder entry.
  assign in_stall_o = !(slot_free && rob_st.room);
  assign accept     = in_valid_i && !in_stall_o;

  mbe_coord u_coord_re (
    .step_i  (step_x_q),
    .pixel_i (pixel_x_i[mbe_pkg::COORD_BITS-1:0]),
    .coord_o (c_re)
  );

  mbe_coord u_coord_im (
    .step_i  (step_y_q),
    .pixel_i (pixel_y_i[mbe_pkg::COORD_BITS-1:0]),
    .coord_o (c_im)
  );

  // A new item starts from z = 0 with no steps taken.
  always_comb begin
    ins_item.valid = 1'b1;
    ins_item.re    = '0;
    ins_item.im    = '0;
    ins_item.c_re  = c_re;
    ins_item.c_im  = c_im;
    ins_item.cnt   = '0;
    ins_item.tag   = rob_st.tag;
  end

  mbe_iter u_iter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ins_valid_i (accept),
    .ins_item_i  (ins_item),
    .limit_i     (limit),
    .slot_free_o (slot_free),
    .busy_o      (loop_busy),
    .retire_o    (retire)
  );

  mbe_rob u_rob (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ins_i          (accept),
    .retire_i       (retire),
    .out_stall_i    (out_stall_i),
    .status_o       (rob_st),
    .out_valid_o    (out_valid_o),
    .escape_count_o (escape_count_o),
    .red_level_o    (red_level_o)
  );

  // An empty reorder buffer means nothing is left in the loop.
  `MBE_ASSERT_IMP(a_drained_loop, rob_st.empty, !loop_busy)
  // Every item that finishes was counted in on acceptance.
  `MBE_ASSERT_NEVER(a_retire_untracked, retire.valid && rob_st.empty)
  // At least one step is always taken.
  `MBE_ASSERT_IMP(a_count_nonzero, out_valid_o, escape_count_o != 8'd0)

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Regression bench for the Mandelbrot escape-time pixel block
// Pixel coordinates are sent in bursts while the result side stalls on its
// own pattern. Every accepted pixel is predicted, from the directed table or
// with a fixed-point orbit model kept in the bench, and each result transfer
// is compared field by field with the oldest prediction. The directed table
// covers the extremes, the small iteration caps and saturating coordinates;
// random phases then sweep the register settings.
// ----------------------------------------------------------------------------

module tb;

  // Widths and register defaults taken from the shared package.
  localparam int STEP_W    = mbe_pkg::STEP_W;
  localparam int CFG_IDX_W = mbe_pkg::CFG_IDX_W;
  localparam logic [STEP_W-1:0] STEP_X_RST = mbe_pkg::STEP_X_RST;
  localparam logic [STEP_W-1:0] STEP_Y_RST = mbe_pkg::STEP_Y_RST;

  // Arithmetic of the orbit: signed words with four integer bits.
  localparam int     FRAC         = mbe_pkg::FRAC_BITS;
  localparam longint WORD_HI      = 64'sd2147483647;
  localparam longint WORD_LO      = -64'sd2147483648;
  localparam longint COORD_OFFSET = longint'(2) << FRAC;
  localparam logic [64:0] ESCAPE_SQ = 65'd1 << (2 * FRAC + 2);

  localparam logic [STEP_W-1:0] STEP_FULL = {STEP_W{1'b1}};
  localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1) << FRAC;

  // Index that lies beyond the register list; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int END_HOLD       = 50;
  localparam int NUM_DIRECTED   = 24;
  localparam int NUM_PHASES     = 8;
  localparam int PIXELS_PER_PHASE = 92;

  typedef struct packed {
    mbe_pkg::cnt_t count;
    logic [7:0]    red;
  } escape_res_t;

  typedef struct packed {
    mbe_pkg::cnt_t     max_iter;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic [10:0]       px;
    logic [10:0]       py;
    logic              typed;
    mbe_pkg::cnt_t     count;
    logic [7:0]        red;
  } pixel_row_t;

  typedef struct packed {
    mbe_pkg::cnt_t     max_iter;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
  } reg_set_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [10:0]          pixel_x_i   = '0;
  logic [10:0]          pixel_y_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [7:0]           escape_count_o;
  logic [7:0]           red_level_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [STEP_W-1:0]    cfg_data_i  = '0;

  // Register copies used by the orbit predictor.
  mbe_pkg::cnt_t     reg_max_iter = mbe_pkg::MAX_ITER_RST;
  logic [STEP_W-1:0] reg_step_x   = STEP_X_RST;
  logic [STEP_W-1:0] reg_step_y   = STEP_Y_RST;

  escape_res_t expected_escapes[$];
  int          mismatches  = 0;
  int          idle_cycles = 0;
  int          burst_left  = 0;
  int          stall_left  = 0;
  stall_mode_e stall_mode  = STALL_NONE;

  mandelbrot_escape_time_pixel_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .escape_count_o (escape_count_o),
    .red_level_o    (red_level_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Clamp a wide value to the signed word range.
  function automatic longint clamp_word(input longint v);
    if (v > WORD_HI) begin
      return WORD_HI;
    end else if (v < WORD_LO) begin
      return WORD_LO;
    end
    return v;
  endfunction

  // Orbit of z = z*z + c from zero, counted until |z| reaches 2 or the step limit.
  function automatic escape_res_t escape_time(input logic [10:0] px, input logic [10:0] py);
    longint      c_re;
    longint      c_im;
    longint      re;
    longint      im;
    longint      rr;
    longint      ii;
    longint      ri;
    logic [64:0] mag_sq;
    int          limit;
    int          k;
    logic        done;
    escape_res_t res;
    c_re  = clamp_word(longint'(reg_step_x) * longint'(px) - COORD_OFFSET);
    c_im  = clamp_word(longint'(reg_step_y) * longint'(py) - COORD_OFFSET);
    re    = 0;
    im    = 0;
    limit = (reg_max_iter > 2) ? int'(reg_max_iter) - 1 : 1;
    k     = 0;
    done  = 1'b0;
    while (!done) begin
      k++;
      // Arithmetic shifts give the floor of each scaled product.
      rr = (re * re) >>> FRAC;
      ii = (im * im) >>> FRAC;
      ri = (re * im) >>> (FRAC - 1);
      re = clamp_word(rr - ii + c_re);
      im = clamp_word(ri + c_im);
      mag_sq = 65'(re * re) + 65'(im * im);
      done = (mag_sq >= ESCAPE_SQ) || (k >= limit);
    end
    res.count = mbe_pkg::cnt_t'(k);
    res.red   = 8'(k * 10);
    return res;
  endfunction

  // Present one register write and hold it until the transfer; the caller
  // lowers the valid once no further write follows.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      mbe_pkg::CFG_MAX_ITER: reg_max_iter = data[7:0];
      mbe_pkg::CFG_STEP_X:   reg_step_x   = data;
      mbe_pkg::CFG_STEP_Y:   reg_step_y   = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_escapes.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the block idle and every result delivered.
  task automatic load_registers(input reg_set_t regs);
    in_valid_i <= 1'b0;
    wait_drained();
    write_reg(mbe_pkg::CFG_MAX_ITER,
              {STEP_W'($urandom) & ~STEP_W'(8'hFF)} | STEP_W'(regs.max_iter));
    write_reg(mbe_pkg::CFG_STEP_X, regs.step_x);
    write_reg(mbe_pkg::CFG_STEP_Y, regs.step_y);
    write_reg(CFG_SPARE, STEP_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Bursts of random length with random gaps, some bursts back to back.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Present one pixel, wait for its transfer and queue its prediction.
  task automatic send_pixel(input logic [10:0] px, input logic [10:0] py,
                            input logic typed, input escape_res_t typed_res);
    in_valid_i <= 1'b1;
    pixel_x_i  <= px;
    pixel_y_i  <= py;
    do @(posedge clk_i); while (in_stall_o);
    expected_escapes.insert(expected_escapes.size(),
                            typed ? typed_res : escape_time(px, py));
  endtask

  // Coordinate biased towards the part of the plane where orbits are long.
  function automatic logic [10:0] pick_coord(input logic [STEP_W-1:0] step);
    int hi;
    hi = (step == 0) ? 2047 : (1 << 30) / int'(step);
    if (hi > 2047) begin
      hi = 2047;
    end
    if ($urandom_range(0, 9) < 4) begin
      return 11'($urandom_range(0, hi));
    end
    return 11'($urandom_range(0, 2047));
  endfunction

  // Result side stalls in modes of random length and density.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HALF:  out_stall_i <= ($urandom_range(0, 1) == 0);
      default:     out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    escape_res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_escapes.size() == 0) begin
        $error("unexpected result: escape_count %0d, red_level %0d",
               escape_count_o, red_level_o);
        mismatches++;
      end else begin
        exp_res = expected_escapes.pop_front();
        if (escape_count_o !== exp_res.count) begin
          $error("escape_count: expected %0d, actual %0d", exp_res.count, escape_count_o);
          mismatches++;
        end
        if (red_level_o !== exp_res.red) begin
          $error("red_level: expected %0d, actual %0d", exp_res.red, red_level_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("mandelbrot_escape_time_pixel_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    pixel_row_t  pixel_rows [NUM_DIRECTED];
    reg_set_t    phases [NUM_PHASES];
    reg_set_t    regs;
    escape_res_t typed_res;
    logic [10:0] px;
    logic [10:0] py;

    // Directed pixels; the register columns are loaded whenever they change.
    pixel_rows = '{
      // Reset registers: corners escape at once, the origin stays bounded.
      '{8'd28,  STEP_X_RST, STEP_Y_RST, 11'd0,    11'd0,    1'b1, 8'd1,   8'd10},
      '{8'd28,  STEP_X_RST, STEP_Y_RST, 11'd2047, 11'd2047, 1'b1, 8'd1,   8'd10},
      '{8'd28,  STEP_X_RST, STEP_Y_RST, 11'd2047, 11'd0,    1'b1, 8'd1,   8'd10},
      '{8'd28,  STEP_X_RST, STEP_Y_RST, 11'd0,    11'd2047, 1'b1, 8'd1,   8'd10},
      '{8'd28,  STEP_X_RST, STEP_Y_RST, 11'd640,  11'd360,  1'b1, 8'd27,  8'd14},
      '{8'd28,  STEP_X_RST, STEP_Y_RST, 11'd320,  11'd360,  1'b0, 8'd0,   8'd0},
      '{8'd28,  STEP_X_RST, STEP_Y_RST, 11'd480,  11'd300,  1'b0, 8'd0,   8'd0},
      '{8'd28,  STEP_X_RST, STEP_Y_RST, 11'd1365, 11'd682,  1'b0, 8'd0,   8'd0},
      '{8'd28,  STEP_X_RST, STEP_Y_RST, 11'd682,  11'd1365, 1'b0, 8'd0,   8'd0},
      '{8'd28,  STEP_X_RST, STEP_Y_RST, 11'd1024, 11'd512,  1'b0, 8'd0,   8'd0},
      '{8'd28,  STEP_X_RST, STEP_Y_RST, 11'd600,  11'd400,  1'b0, 8'd0,   8'd0},
      // Small caps allow a single step only; a cap of three allows two.
      '{8'd0,   STEP_X_RST, STEP_Y_RST, 11'd640,  11'd360,  1'b1, 8'd1,   8'd10},
      '{8'd1,   STEP_X_RST, STEP_Y_RST, 11'd640,  11'd360,  1'b1, 8'd1,   8'd10},
      '{8'd2,   STEP_X_RST, STEP_Y_RST, 11'd640,  11'd360,  1'b1, 8'd1,   8'd10},
      '{8'd3,   STEP_X_RST, STEP_Y_RST, 11'd640,  11'd360,  1'b1, 8'd2,   8'd20},
      // Largest cap, where the red byte wraps.
      '{8'd255, STEP_X_RST, STEP_Y_RST, 11'd640,  11'd360,  1'b1, 8'd254, 8'd236},
      '{8'd255, STEP_X_RST, STEP_Y_RST, 11'd500,  11'd420,  1'b0, 8'd0,   8'd0},
      // Zero steps pin c to the corner of the plane.
      '{8'd255, '0,         '0,         11'd640,  11'd360,  1'b1, 8'd1,   8'd10},
      '{8'd255, '0,         '0,         11'd2047, 11'd2047, 1'b1, 8'd1,   8'd10},
      // Full steps saturate the coordinate.
      '{8'd255, STEP_FULL,  STEP_FULL,  11'd2047, 11'd2047, 1'b1, 8'd1,   8'd10},
      '{8'd255, STEP_FULL,  '0,         11'd2047, 11'd0,    1'b1, 8'd1,   8'd10},
      // Unit steps land on exact lattice points.
      '{8'd255, STEP_ONE,   STEP_ONE,   11'd2,    11'd2,    1'b1, 8'd254, 8'd236},
      '{8'd255, STEP_ONE,   STEP_ONE,   11'd1,    11'd2,    1'b0, 8'd0,   8'd0},
      '{8'd255, STEP_ONE,   STEP_ONE,   11'd0,    11'd1,    1'b1, 8'd1,   8'd10}
    };

    phases = '{
      '{8'd28,  STEP_X_RST,      STEP_Y_RST},
      '{8'd255, STEP_X_RST,      STEP_Y_RST},
      '{8'd0,   STEP_ONE,        STEP_ONE},
      '{8'd2,   '0,              '0},
      '{8'd255, STEP_FULL,       STEP_FULL},
      '{8'd64,  STEP_W'(1 << 18), STEP_W'(1 << 18)},
      '{8'd100, STEP_W'(1 << 19), STEP_W'(1 << 19)},
      '{8'd28,  STEP_X_RST,      STEP_Y_RST}
    };
    // The last phase draws its registers at random.
    phases[NUM_PHASES-1].max_iter = mbe_pkg::cnt_t'($urandom_range(0, 255));
    phases[NUM_PHASES-1].step_x   = STEP_W'($urandom_range(0, 1 << 22));
    phases[NUM_PHASES-1].step_y   = STEP_W'($urandom_range(0, 1 << 22));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (pixel_rows[r].max_iter != reg_max_iter || pixel_rows[r].step_x != reg_step_x ||
          pixel_rows[r].step_y != reg_step_y) begin
        regs = '{pixel_rows[r].max_iter, pixel_rows[r].step_x, pixel_rows[r].step_y};
        load_registers(regs);
      end
      pace_sender();
      typed_res = '{pixel_rows[r].count, pixel_rows[r].red};
      send_pixel(pixel_rows[r].px, pixel_rows[r].py, pixel_rows[r].typed, typed_res);
    end

    // Random pixels under each register setting; every phase starts drained.
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_registers(phases[p]);
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        pace_sender();
        px = pick_coord(reg_step_x);
        py = pick_coord(reg_step_y);
        send_pixel(px, py, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (END_HOLD) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("mandelbrot_escape_time_pixel_top regression: pass");
    end else begin
      $display("mandelbrot_escape_time_pixel_top regression: fail");
    end
    $finish;
  end

endmodule
